FILE: rtl/dnl_pkg.sv
// shared types and constants for the directory entry name lookup
// no dependencies; imported by every rtl module of the block
`default_nettype none

package dnl_pkg;

	// default block size in bytes
	localparam int BLOCK_BYTES_DEF = 1024;

	// bytes of the target name that can ever compare equal
	localparam int NAME_BYTES = 16;

	// register indexes on the config port (byte address bits [4:3])
	localparam logic [1:0] REG_NAME_LOW  = 2'd0;
	localparam logic [1:0] REG_NAME_HIGH = 2'd1;
	localparam logic [1:0] REG_NAME_LEN  = 2'd2;

	// byte positions inside an entry header
	localparam int REL_INODE_END = 4;
	localparam int REL_RLEN_LO   = 4;
	localparam int REL_RLEN_HI   = 5;
	localparam int REL_NAME_LEN  = 6;
	localparam int REL_TYPE      = 7;
	localparam int HDR_BYTES     = 8;

	// configured target name
	typedef struct packed {
		logic [63:0] name_low;
		logic [63:0] name_high;
		logic [4:0]  name_size;
	} cfg_t;

	// report for one block
	typedef struct packed {
		logic        found;
		logic [31:0] inode;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/dnl_apb.sv
// apb-style register file holding the target name
// depends on dnl_pkg for register indexes and cfg_t
`default_nettype none

module dnl_apb
	import dnl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [63:0] name_low_q;
	logic [63:0] name_high_q;
	logic [4:0]  name_size_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q  <= '0;
			name_high_q <= '0;
			name_size_q <= 5'd1;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				REG_NAME_LOW:  name_low_q  <= pwdata;
				REG_NAME_HIGH: name_high_q <= pwdata;
				REG_NAME_LEN:  name_size_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[4:3])
			REG_NAME_LOW:  prdata = name_low_q;
			REG_NAME_HIGH: prdata = name_high_q;
			REG_NAME_LEN:  prdata = {59'd0, name_size_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.name_low  = name_low_q;
	assign cfg.name_high = name_high_q;
	assign cfg.name_size = name_size_q;

endmodule

`default_nettype wire

FILE: rtl/dnl_scan.sv
// entry parser: header fields, per-entry name compare, first-match record
// depends on dnl_pkg for header positions, cfg_t and result_t
`default_nettype none

module dnl_scan
	import dnl_pkg::*;
#(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       block_end,
	input  wire cfg_t       cfg,
	output result_t         res
);

	localparam int OFF_W = $clog2(BLOCK_BYTES + 1);
	localparam int SUM_W = ((OFF_W > 16) ? OFF_W : 16) + 1;
	localparam logic [OFF_W-1:0] BLOCK_LIM = OFF_W'(BLOCK_BYTES);
	localparam logic [SUM_W-1:0] BLOCK_LIM_W = SUM_W'(BLOCK_BYTES);

	logic [OFF_W-1:0] offset_q, offset_d;
	logic [OFF_W-1:0] start_q, start_d;
	logic [31:0]      inode_q, inode_d;
	logic [15:0]      rlen_q, rlen_d;
	logic [7:0]       nlen_q, nlen_d;
	logic             equal_q, equal_d;
	logic             stop_q, stop_d;
	logic [31:0]      match_q, match_d;

	logic [OFF_W-1:0] rel;
	logic [OFF_W-1:0] name_idx;
	logic [SUM_W-1:0] rel_w, idx_w, nlen_w, rlen_w;
	logic [127:0]     target;
	logic [7:0]       target_byte;
	logic             byte_eq;
	logic             finish;
	logic [31:0]      inode_base;

	assign rel      = offset_q - start_q;
	assign name_idx = rel - OFF_W'(HDR_BYTES);
	assign rel_w    = SUM_W'(rel);
	assign idx_w    = SUM_W'(name_idx);
	assign nlen_w   = SUM_W'(nlen_q);
	assign rlen_w   = SUM_W'(rlen_q);

	// target byte at the current name index
	assign target      = {cfg.name_high, cfg.name_low};
	assign target_byte = target[8*name_idx[3:0] +: 8];
	assign byte_eq     = (idx_w < SUM_W'(NAME_BYTES)) && (target_byte == data_byte);
	assign inode_base  = (rel == '0) ? 32'd0 : inode_q;

	// next state for one transfer
	always_comb begin
		offset_d = offset_q;
		start_d  = start_q;
		inode_d  = inode_q;
		rlen_d   = rlen_q;
		nlen_d   = nlen_q;
		equal_d  = equal_q;
		stop_d   = stop_q;
		match_d  = match_q;
		finish   = 1'b0;
		if (step && offset_q < BLOCK_LIM) begin
			offset_d = offset_q + OFF_W'(1);
			if (!stop_q && offset_q >= start_q) begin
				if (rel < OFF_W'(REL_INODE_END)) begin
					// inode bytes, little-endian; first byte opens a new entry
					if (rel == '0) begin
						rlen_d  = '0;
						nlen_d  = '0;
						equal_d = 1'b1;
					end
					inode_d = inode_base | (32'(data_byte) << (8 * rel[1:0]));
				end else if (rel == OFF_W'(REL_RLEN_LO)) begin
					rlen_d = {8'd0, data_byte};
				end else if (rel == OFF_W'(REL_RLEN_HI)) begin
					rlen_d = {data_byte, rlen_q[7:0]};
					// short record or record past the block
					if (rlen_d < 16'(HDR_BYTES)
						|| SUM_W'(start_q) + SUM_W'(rlen_d) > BLOCK_LIM_W) begin
						stop_d = 1'b1;
					end
				end else begin
					if (rel == OFF_W'(REL_NAME_LEN)) begin
						nlen_d = data_byte;
						// name longer than the record
						if (SUM_W'(HDR_BYTES) + SUM_W'(data_byte) > rlen_w) begin
							stop_d = 1'b1;
						end
					end else if (rel == OFF_W'(REL_TYPE)) begin
						finish = (nlen_q == 8'd0);
					end else if (idx_w < nlen_w) begin
						if (!byte_eq) begin
							equal_d = 1'b0;
						end
						finish = (idx_w == nlen_w - SUM_W'(1));
					end
					// first exact match with a used inode ends the scan
					if (finish && equal_d && nlen_q == {3'd0, cfg.name_size}
						&& inode_q != 32'd0 && match_q == 32'd0) begin
						match_d = inode_q;
						stop_d  = 1'b1;
					end
					// last byte of the record: move to the next entry
					if (!stop_d && rel_w == rlen_w - SUM_W'(1)) begin
						start_d = OFF_W'(SUM_W'(start_q) + rlen_w);
					end
				end
			end
		end
		res.found = (match_d != 32'd0);
		res.inode = match_d;
		// block end: back to the idle state for the next block
		if (step && block_end) begin
			offset_d = '0;
			start_d  = '0;
			inode_d  = '0;
			rlen_d   = '0;
			nlen_d   = '0;
			equal_d  = 1'b1;
			stop_d   = 1'b0;
			match_d  = '0;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			start_q  <= '0;
			inode_q  <= '0;
			rlen_q   <= '0;
			nlen_q   <= '0;
			equal_q  <= 1'b1;
			stop_q   <= 1'b0;
			match_q  <= '0;
		end else begin
			offset_q <= offset_d;
			start_q  <= start_d;
			inode_q  <= inode_d;
			rlen_q   <= rlen_d;
			nlen_q   <= nlen_d;
			equal_q  <= equal_d;
			stop_q   <= stop_d;
			match_q  <= match_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/directory_entry_name_lookup.sv
// top level of the directory entry name lookup: input stage, scan, result register
// depends on dnl_pkg, dnl_apb and dnl_scan
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   input   | in        | in_valid / in_ready  | data_byte, block_end
//   result  | out       | out_valid/ out_ready | found, inode_number
//   config  | in        | apb, pready tied 1   | paddr, pwdata, prdata
//
// one byte per cycle unless a waiting result holds a block_end byte: a transfer lands in
// the input register, the scan updates its state from it and, on the block's last byte,
// loads the result register, which then offers the result.
// reset clears the scan state and sets the target length to 1. a waiting result
// stalls only the next block_end byte; other bytes keep flowing.
`default_nettype none

module directory_entry_name_lookup
	import dnl_pkg::*;
#(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  data_byte,
	input  wire logic        block_end,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             found,
	output logic      [31:0] inode_number,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);

	cfg_t        cfg;
	result_t     res;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        valid_s1;
	logic        out_free;
	logic        step;
	logic        found_q;
	logic [31:0] inode_q;
	logic        out_valid_q;

	dnl_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// flow control: only a block_end byte needs room in the result register
	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && (!end_s1 || out_free);
	assign in_ready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			end_s1  <= block_end;
		end
	end

	dnl_scan #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.block_end (end_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && end_s1) begin
			found_q <= res.found;
			inode_q <= res.inode;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign inode_number = inode_q;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// testbench for directory_entry_name_lookup: directed and random directory blocks,
// every block report checked against a lookup model kept inside the testbench
// depends on dnl_pkg and the rtl of the block
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dnl_pkg::*;

	localparam int DIR_BLOCK_BYTES = BLOCK_BYTES_DEF;
	localparam int QUIET_LIMIT     = 2000;
	localparam int RANDOM_BYTES    = 120;
	localparam bit [31:0] TAIL_INODE = 32'h1234_5678;

	// how the name bytes of a built entry relate to the target name
	typedef enum bit [1:0] {
		NK_TARGET,
		NK_FLIP_LAST,
		NK_RANDOM
	} name_kind_t;

	// one byte of a block on its way to the input channel
	typedef struct packed {
		bit [7:0]  data;
		bit        last;
		bit        fixed;
		bit        ffound;
		bit [31:0] finode;
	} dir_byte_t;

	// one directed block: a single entry, optionally followed by a matching one
	typedef struct packed {
		bit [4:0]   tlen;
		bit [31:0]  ino;
		bit [15:0]  rlen;
		bit [7:0]   nlen;
		name_kind_t kind;
		int         body;
		bit         tail;
		bit         fixed;
		bit         ffound;
		bit [31:0]  finode;
	} dir_case_t;

	// directed blocks; the first one runs on the reset target (one zero byte)
	dir_case_t dir_cases [21] = '{
		'{5'd1,  32'hFFFF_FFFF, 16'd12,     8'd1,  NK_TARGET,    12,   1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{5'd5,  32'd1,         16'd16,     8'd5,  NK_TARGET,    16,   1'b0, 1'b1, 1'b1, 32'd1},
		'{5'd5,  32'd2,         16'd16,     8'd5,  NK_FLIP_LAST, 16,   1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'd3,         16'd16,     8'd4,  NK_TARGET,    16,   1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'd4,         16'd16,     8'd6,  NK_TARGET,    16,   1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'd0,         16'd16,     8'd5,  NK_TARGET,    16,   1'b1, 1'b1, 1'b1, TAIL_INODE},
		'{5'd5,  32'd7,         16'd16,     8'd5,  NK_TARGET,    16,   1'b1, 1'b1, 1'b1, 32'd7},
		'{5'd5,  32'd9,         16'd0,      8'd5,  NK_TARGET,    16,   1'b1, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'd9,         16'd7,      8'd5,  NK_TARGET,    16,   1'b1, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'd10,        16'hFFFF,   8'd5,  NK_TARGET,    20,   1'b1, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'd11,        16'd12,     8'd5,  NK_TARGET,    12,   1'b1, 1'b1, 1'b0, 32'd0},
		'{5'd16, 32'h8000_0000, 16'd24,     8'd16, NK_TARGET,    24,   1'b0, 1'b1, 1'b1, 32'h8000_0000},
		'{5'd16, 32'd12,        16'd24,     8'd16, NK_FLIP_LAST, 24,   1'b1, 1'b0, 1'b0, 32'd0},
		'{5'd0,  32'h55,        16'd8,      8'd0,  NK_TARGET,    8,    1'b0, 1'b1, 1'b1, 32'h55},
		'{5'd17, 32'h66,        16'd28,     8'd17, NK_TARGET,    28,   1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd31, 32'h77,        16'd40,     8'd31, NK_TARGET,    40,   1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'h88,        16'd16,     8'd5,  NK_TARGET,    12,   1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'h99,        16'd16,     8'd5,  NK_TARGET,    3,    1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd5,  32'hAA,        16'd16,     8'd5,  NK_TARGET,    1,    1'b0, 1'b1, 1'b0, 32'd0},
		'{5'd3,  32'hA5A5_A5A5, 16'd1024,   8'd3,  NK_TARGET,    16,   1'b0, 1'b1, 1'b1, 32'hA5A5_A5A5},
		'{5'd8,  32'h0001_0203, 16'd16,     8'd8,  NK_RANDOM,    16,   1'b1, 1'b0, 1'b0, 32'd0}
	};

	// dut ports
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        out_ready = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [4:0]  paddr     = '0;
	logic [63:0] pwdata    = '0;
	dir_byte_t   cur_item  = '0;
	logic        in_ready;
	logic        found;
	logic [31:0] inode_number;
	logic        out_valid;
	logic [63:0] prdata;
	logic        pready;

	// target name as the lookup model sees it
	bit [63:0] tgt_low  = '0;
	bit [63:0] tgt_high = '0;
	bit [4:0]  tgt_len  = 5'd1;

	// lookup model state for the block in progress
	bit [10:0] scan_pos    = '0;
	bit [10:0] ent_start   = '0;
	bit [31:0] ent_inode   = '0;
	bit [15:0] rec_len     = '0;
	bit [7:0]  ent_nlen    = '0;
	bit        name_ok     = 1'b1;
	bit        scan_halted = 1'b0;
	bit [31:0] hit_inode   = '0;

	// stimulus and scoreboard
	bit [7:0]  blk_q [$];
	dir_byte_t send_q [$];
	result_t   pending_lookups [$];
	result_t   pred_res;
	result_t   want;
	bit        steady       = 1'b0;
	int        queued_cnt   = 0;
	int        accepted_cnt = 0;
	int        result_cnt   = 0;
	int        hit_cnt      = 0;
	int        err_cnt      = 0;
	int        quiet_cycles = 0;
	int        settings_cnt = 1;

	directory_entry_name_lookup #(
		.BLOCK_BYTES(DIR_BLOCK_BYTES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (cur_item.data),
		.block_end   (cur_item.last),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.found       (found),
		.inode_number(inode_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #10 clk = ~clk;

	// target name byte, zero beyond the comparable bytes
	function automatic bit [7:0] tgt_byte(input int idx);
		if (idx < 8)
			return tgt_low[8*idx +: 8];
		if (idx < 16)
			return tgt_high[8*(idx-8) +: 8];
		return 8'h00;
	endfunction

	// record the entry as the match when its whole name agreed
	function automatic void close_entry_name();
		if (name_ok && ent_nlen == 8'(tgt_len) && ent_inode != 0 && hit_inode == 0) begin
			hit_inode   = ent_inode;
			scan_halted = 1'b1;
		end
	endfunction

	// advance the lookup model by one byte; returns 1 with the report on the last byte
	function automatic bit predict_lookup(input bit [7:0] b, input bit last, output result_t r);
		int rel;
		r = '0;
		if (scan_pos < DIR_BLOCK_BYTES) begin
			if (!scan_halted && scan_pos >= ent_start) begin
				rel = int'(scan_pos) - int'(ent_start);
				if (rel < 4) begin
					if (rel == 0) begin
						ent_inode = '0;
						rec_len   = '0;
						ent_nlen  = '0;
						name_ok   = 1'b1;
					end
					ent_inode[8*rel +: 8] = b;
				end else if (rel == 4) begin
					rec_len[7:0] = b;
				end else if (rel == 5) begin
					rec_len[15:8] = b;
					if (rec_len < 8 || int'(ent_start) + int'(rec_len) > DIR_BLOCK_BYTES)
						scan_halted = 1'b1;
				end else begin
					if (rel == 6) begin
						ent_nlen = b;
						if (8 + int'(ent_nlen) > int'(rec_len))
							scan_halted = 1'b1;
					end else if (rel == 7) begin
						if (ent_nlen == 0)
							close_entry_name();
					end else if (rel - 8 < int'(ent_nlen)) begin
						if (!(rel - 8 < NAME_BYTES && tgt_byte(rel - 8) == b))
							name_ok = 1'b0;
						if (rel - 8 == int'(ent_nlen) - 1)
							close_entry_name();
					end
					// next entry begins after this record
					if (!scan_halted && rel == int'(rec_len) - 1)
						ent_start = 11'(ent_start + rec_len);
				end
			end
			scan_pos = scan_pos + 1'b1;
		end
		if (!last)
			return 1'b0;
		r.found = (hit_inode != 0);
		r.inode = hit_inode;
		scan_pos    = '0;
		ent_start   = '0;
		ent_inode   = '0;
		rec_len     = '0;
		ent_nlen    = '0;
		name_ok     = 1'b1;
		scan_halted = 1'b0;
		hit_inode   = '0;
		return 1'b1;
	endfunction

	// input channel driver with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (send_q.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
				cur_item <= send_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result channel back-pressure
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 23);
	end

	// transfer monitor, scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				accepted_cnt++;
				if (predict_lookup(cur_item.data, cur_item.last, pred_res)) begin
					if (cur_item.fixed) begin
						pred_res.found = cur_item.ffound;
						pred_res.inode = cur_item.finode;
					end
					pending_lookups.push_back(pred_res);
				end
			end
			if (out_valid && out_ready) begin
				result_cnt++;
				if (found)
					hit_cnt++;
				if (pending_lookups.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("report %0d arrived with none pending: found=%0b inode=%h",
							result_cnt, found, inode_number);
				end else begin
					want = pending_lookups.pop_front();
					if (found !== want.found || inode_number !== want.inode) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("report %0d: expected found=%0b inode=%h, got found=%0b inode=%h",
								result_cnt, want.found, want.inode, found, inode_number);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// apb write: setup cycle, then access cycle
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_NAME_LOW:  tgt_low  = val;
			REG_NAME_HIGH: tgt_high = val;
			REG_NAME_LEN:  tgt_len  = val[4:0];
			default: ;
		endcase
	endtask

	// length write with random bits above the length field
	task automatic write_len(input bit [4:0] len);
		write_reg(REG_NAME_LEN, {32'($urandom), 27'($urandom), len});
	endtask

	// append body bytes of one entry: header, name, then filler
	task automatic append_entry(input bit [31:0] ino, input bit [15:0] rlen, input bit [7:0] nlen,
			input name_kind_t kind, input int body);
		bit [7:0] hdr [8];
		bit [7:0] nb;
		int k;
		hdr = '{ino[7:0], ino[15:8], ino[23:16], ino[31:24], rlen[7:0], rlen[15:8], nlen,
			8'($urandom)};
		for (k = 0; k < body; k++) begin
			if (k < 8) begin
				nb = hdr[k];
			end else if (k - 8 < int'(nlen)) begin
				nb = (k - 8 < NAME_BYTES) ? tgt_byte(k - 8) : 8'($urandom);
				if (kind == NK_RANDOM)
					nb = 8'($urandom);
				else if (kind == NK_FLIP_LAST && k - 8 == int'(nlen) - 1)
					nb = nb ^ 8'($urandom_range(1, 255));
			end else begin
				nb = 8'($urandom);
			end
			blk_q.push_back(nb);
		end
	endtask

	// append an entry whose name is the current target
	task automatic append_match(input bit [31:0] ino);
		int mr;
		mr = ((8 + int'(tgt_len) + 3) / 4) * 4;
		append_entry(ino, 16'(mr), 8'(tgt_len), NK_TARGET, mr);
	endtask

	// hand the built block to the driver, marking its last byte
	task automatic ship_block(input bit fx, input bit ff, input bit [31:0] fi);
		dir_byte_t it;
		foreach (blk_q[j]) begin
			it        = '0;
			it.data   = blk_q[j];
			it.last   = (j == blk_q.size() - 1);
			it.fixed  = fx && it.last;
			it.ffound = ff;
			it.finode = fi;
			send_q.push_back(it);
		end
		queued_cnt += blk_q.size();
		blk_q.delete();
	endtask

	// wait until every byte is in and every report is out, then let the block settle
	task automatic drain();
		while (accepted_cnt != queued_cnt)
			@(posedge clk);
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random block: mostly well-formed entry chains, some broken headers, some noise
	task automatic gen_random_block();
		int r;
		int q;
		int k;
		bit [31:0]  ino;
		bit [7:0]   nlen;
		bit [15:0]  rlen;
		name_kind_t kind;
		r = $urandom_range(99);
		if (r < 75) begin
			repeat ($urandom_range(1, 2)) begin
				case ($urandom_range(7))
					0:       ino = '0;
					1, 2:    ino = $urandom_range(1, 255);
					default: ino = $urandom;
				endcase
				q = $urandom_range(99);
				if (q < 50)
					nlen = 8'(tgt_len);
				else if (q < 70)
					nlen = (tgt_len == 0 || $urandom_range(1)) ? 8'(tgt_len) + 8'd1
						: 8'(tgt_len) - 8'd1;
				else
					nlen = 8'($urandom_range(0, 20));
				q = $urandom_range(99);
				if (nlen == 8'(tgt_len))
					kind = (q < 60) ? NK_TARGET : (q < 85) ? NK_FLIP_LAST : NK_RANDOM;
				else
					kind = (q < 50) ? NK_TARGET : NK_RANDOM;
				rlen = 16'(8 + int'(nlen) + int'($urandom_range(0, 5)));
				append_entry(ino, rlen, nlen, kind, int'(rlen));
			end
			// cut the block short or run on past the last entry
			q = $urandom_range(99);
			if (q < 15) begin
				k = $urandom_range(1, blk_q.size() - 1);
				repeat (k) void'(blk_q.pop_back());
			end else if (q < 30) begin
				repeat ($urandom_range(1, 6)) blk_q.push_back(8'($urandom));
			end
		end else if (r < 90) begin
			if ($urandom_range(1))
				append_entry($urandom | 1, 16'd12, 8'd2, NK_RANDOM, 12);
			ino = $urandom | 1;
			nlen = 8'(tgt_len);
			case ($urandom_range(3))
				0: rlen = '0;
				1: rlen = 16'($urandom_range(1, 7));
				2: rlen = $urandom_range(1) ? 16'($urandom_range(1000, 1100))
					: 16'($urandom_range(1101, 65535));
				default: begin
					rlen = 16'(8 + $urandom_range(0, 8));
					nlen = 8'(int'(rlen) - 8 + int'($urandom_range(1, 20)));
				end
			endcase
			append_entry(ino, rlen, nlen, NK_TARGET, 8 + int'($urandom_range(0, 12)));
			if ($urandom_range(1))
				append_match($urandom | 1);
		end else begin
			repeat ($urandom_range(1, 40)) blk_q.push_back(8'($urandom));
		end
		ship_block(1'b0, 1'b0, '0);
	endtask

	// reset, directed blocks, then random phases
	initial begin
		int phase;
		int rnd_blocks;
		int dir_bytes;
		phase      = 0;
		rnd_blocks = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks, one at a time
		foreach (dir_cases[i]) begin
			if (i == 1) begin
				write_reg(REG_NAME_LOW,  64'h6867_6665_6463_6261);
				write_reg(REG_NAME_HIGH, 64'h706F_6E6D_6C6B_6A69);
			end
			if (dir_cases[i].tlen != tgt_len) begin
				write_len(dir_cases[i].tlen);
				settings_cnt++;
			end
			append_entry(dir_cases[i].ino, dir_cases[i].rlen, dir_cases[i].nlen,
				dir_cases[i].kind, dir_cases[i].body);
			if (dir_cases[i].tail)
				append_match(TAIL_INODE);
			ship_block(dir_cases[i].fixed, dir_cases[i].ffound, dir_cases[i].finode);
			drain();
		end
		dir_bytes = queued_cnt;

		// random phases, each under its own target name
		while (queued_cnt < dir_bytes + RANDOM_BYTES || phase < 6) begin
			case (phase)
				0: begin
					write_reg(REG_NAME_LOW, '0);
					write_reg(REG_NAME_HIGH, '0);
				end
				1: begin
					write_reg(REG_NAME_LOW, '1);
					write_reg(REG_NAME_HIGH, '1);
				end
				default: begin
					write_reg(REG_NAME_LOW, {32'($urandom), 32'($urandom)});
					write_reg(REG_NAME_HIGH, {32'($urandom), 32'($urandom)});
				end
			endcase
			case (phase)
				0: write_len(5'd1);
				1: write_len(5'd16);
				2: write_len(5'd0);
				3: write_len(5'd31);
				4: write_len(5'd17);
				default: begin
					if ($urandom_range(9) == 0)
						write_len(5'($urandom_range(0, 31)));
					else
						write_len(5'($urandom_range(1, $urandom_range(1, 16))));
				end
			endcase
			settings_cnt++;
			steady = (phase == 5);
			repeat ((phase == 5) ? 2 : 1) begin
				gen_random_block();
				rnd_blocks++;
			end
			drain();
			steady = 1'b0;
			phase++;
		end

		repeat (8) @(posedge clk);
		err_cnt += pending_lookups.size();
		$display("covered %0d bytes in %0d blocks (%0d random), %0d reports with a match",
			accepted_cnt, result_cnt, rnd_blocks, hit_cnt);
		$display("target settings used: %0d, mismatches: %0d", settings_cnt, err_cnt);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
